// ----- rtl/sorted_site_join_clean_filter_assert.svh -----
// Assertion macros used by the site join back stage RTL.
`ifndef SORTED_SITE_JOIN_CLEAN_FILTER_ASSERT_SVH
`define SORTED_SITE_JOIN_CLEAN_FILTER_ASSERT_SVH

`ifndef SYNTH
// Property that must hold at every clock edge outside reset.
`define SSJ_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("site join assertion failed");
// Condition that must never be true outside reset.
`define SSJ_ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
        else $error("site join forbidden condition seen");
`else
`define SSJ_ASSERT(lbl, clk, rstn, prop)
`define SSJ_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

// ----- rtl/ssj_pkg.sv -----
// Shared types, codes and helpers for the sorted site join block.
package ssj_pkg;

    // Input record kinds.
    localparam logic [1:0] MODE_S1_REC = 2'd0;
    localparam logic [1:0] MODE_S2_REC = 2'd1;
    localparam logic [1:0] MODE_S1_END = 2'd2;
    localparam logic [1:0] MODE_S2_END = 2'd3;

    // Result actions.
    localparam logic [2:0] ACT_NEED    = 3'd0;
    localparam logic [2:0] ACT_SUMMARY = 3'd1;
    localparam logic [2:0] ACT_KEEP    = 3'd2;
    localparam logic [2:0] ACT_UNCLEAN = 3'd3;
    localparam logic [2:0] ACT_MISS    = 3'd4;
    localparam logic [2:0] ACT_ORDER   = 3'd5;
    localparam logic [2:0] ACT_BADREF  = 3'd6;
    localparam logic [2:0] ACT_TOTALS  = 3'd7;

    // Reference base codes.
    localparam logic [2:0] BASE_A = 3'd0;
    localparam logic [2:0] BASE_T = 3'd1;
    localparam logic [2:0] BASE_C = 3'd2;
    localparam logic [2:0] BASE_G = 3'd3;

    // Queue between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

    // Classified record as handed from the front to the back.
    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  chromosome;
        logic [31:0] position;
        logic        clean;
        logic        bad_ref;
    } ssj_item_t;

    // One result transaction without the last flag.
    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  chromosome;
        logic [31:0] position;
        logic [31:0] found;
        logic [31:0] missed;
        logic [31:0] lines;
    } ssj_result_t;

    // Saturating increment of a 32-bit counter.
    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == COUNT_MAX) ? v : v + 32'd1;
    endfunction

endpackage

// ----- rtl/sorted_site_join_clean_filter.sv -----
// Top level of the sorted site join with clean filter.
//
// Input channel (s_*): one record per transaction, either a stream-1 site, a
// stream-2 site, or an end marker for either stream, as selected by s_mode.
// Output channel (m_*): decisions, need-more requests, per-chromosome
// summaries, order and reference notices, and totals. m_last marks the last
// result produced by one input transaction; inputs may produce none.
// Throughput: one input transaction per cycle when each yields at most one
// result and the receiver does not stall. An input that yields k results holds
// the back end until all k are loaded; the output register takes one per cycle.
// A record's first result passes through the front register, which loads at
// the accepting edge, then through the queue and then the output register.
// A four-entry queue between the front and the back lets the input keep
// flowing while the back end works through multi-result records.
// When the receiver stalls, the result is held in the output register and the
// queue fills; s_ready drops only once the queue and front register are full.
// Reset (aresetn low at a clock edge) clears the join state, counters and
// all queued transactions.
module sorted_site_join_clean_filter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [7:0]  s_chromosome,
    input  logic [31:0] s_position,
    input  logic [2:0]  s_reference_base,
    input  logic [15:0] s_fwd_a,
    input  logic [15:0] s_fwd_t,
    input  logic [15:0] s_fwd_c,
    input  logic [15:0] s_fwd_g,
    input  logic [15:0] s_rev_a,
    input  logic [15:0] s_rev_t,
    input  logic [15:0] s_rev_c,
    input  logic [15:0] s_rev_g,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_action,
    output logic [7:0]  m_site_chromosome,
    output logic [31:0] m_site_position,
    output logic [31:0] m_found_count,
    output logic [31:0] m_not_found_count,
    output logic [31:0] m_line_count,
    output logic        m_last
);
    import ssj_pkg::*;

    logic        front_valid;
    logic        front_ready;
    ssj_item_t   front_item;
    logic        queue_valid;
    logic        queue_ready;
    ssj_item_t   queue_item;
    ssj_result_t result;

    // Classification front end.
    ssj_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_mode           (s_mode),
        .s_chromosome     (s_chromosome),
        .s_position       (s_position),
        .s_reference_base (s_reference_base),
        .s_fwd_a          (s_fwd_a),
        .s_fwd_t          (s_fwd_t),
        .s_fwd_c          (s_fwd_c),
        .s_fwd_g          (s_fwd_g),
        .s_rev_a          (s_rev_a),
        .s_rev_t          (s_rev_t),
        .s_rev_c          (s_rev_c),
        .s_rev_g          (s_rev_g),
        .q_valid          (front_valid),
        .q_ready          (front_ready),
        .q_item           (front_item)
    );

    // Decoupling queue.
    ssj_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (front_valid),
        .wr_ready (front_ready),
        .wr_item  (front_item),
        .rd_valid (queue_valid),
        .rd_ready (queue_ready),
        .rd_item  (queue_item)
    );

    // Join and result back end.
    ssj_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (queue_valid),
        .q_ready  (queue_ready),
        .q_item   (queue_item),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (result),
        .m_last   (m_last)
    );

    assign m_action          = result.action;
    assign m_site_chromosome = result.chromosome;
    assign m_site_position   = result.position;
    assign m_found_count     = result.found;
    assign m_not_found_count = result.missed;
    assign m_line_count      = result.lines;

endmodule

// ----- rtl/ssj_front.sv -----
// Front stage: accepts input records and classifies each site as clean or not.
module ssj_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_mode,
    input  logic [7:0]           s_chromosome,
    input  logic [31:0]          s_position,
    input  logic [2:0]           s_reference_base,
    input  logic [15:0]          s_fwd_a,
    input  logic [15:0]          s_fwd_t,
    input  logic [15:0]          s_fwd_c,
    input  logic [15:0]          s_fwd_g,
    input  logic [15:0]          s_rev_a,
    input  logic [15:0]          s_rev_t,
    input  logic [15:0]          s_rev_c,
    input  logic [15:0]          s_rev_g,
    output logic                 q_valid,
    input  logic                 q_ready,
    output ssj_pkg::ssj_item_t   q_item
);
    import ssj_pkg::*;

    logic        stage_valid_reg;
    logic        stage_valid_next;
    ssj_item_t   stage_item_reg;
    ssj_item_t   stage_item_next;
    logic [18:0] coverage;
    logic [16:0] ref_reads;
    logic        bad_ref;
    logic        clean;

    // Coverage is the sum of all eight counts.
    assign coverage = {3'b0, s_fwd_a} + {3'b0, s_fwd_t} + {3'b0, s_fwd_c} + {3'b0, s_fwd_g}
                    + {3'b0, s_rev_a} + {3'b0, s_rev_t} + {3'b0, s_rev_c} + {3'b0, s_rev_g};

    // Reads that agree with the reference base on both strands.
    always_comb begin
        case (s_reference_base)
            BASE_A:  ref_reads = {1'b0, s_fwd_a} + {1'b0, s_rev_a};
            BASE_T:  ref_reads = {1'b0, s_fwd_t} + {1'b0, s_rev_t};
            BASE_C:  ref_reads = {1'b0, s_fwd_c} + {1'b0, s_rev_c};
            BASE_G:  ref_reads = {1'b0, s_fwd_g} + {1'b0, s_rev_g};
            default: ref_reads = 17'd0;
        endcase
    end

    assign bad_ref = (s_reference_base > BASE_G);
    assign clean   = !bad_ref && (coverage != 19'd0) && ({2'b0, ref_reads} == coverage);

    // The stage register takes a new record whenever it is empty or draining.
    assign s_ready = !stage_valid_reg || q_ready;

    always_comb begin
        stage_valid_next = stage_valid_reg;
        stage_item_next  = stage_item_reg;
        if (s_ready) begin
            stage_valid_next           = s_valid;
            stage_item_next.mode       = s_mode;
            stage_item_next.chromosome = s_chromosome;
            stage_item_next.position   = s_position;
            stage_item_next.clean      = clean;
            stage_item_next.bad_ref    = bad_ref;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
        end else begin
            stage_valid_reg <= stage_valid_next;
        end
        stage_item_reg <= stage_item_next;
    end

    assign q_valid = stage_valid_reg;
    assign q_item  = stage_item_reg;

endmodule

// ----- rtl/ssj_fifo.sv -----
// Short queue of classified records between the front and the back.
module ssj_fifo (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 wr_valid,
    output logic                 wr_ready,
    input  ssj_pkg::ssj_item_t   wr_item,
    output logic                 rd_valid,
    input  logic                 rd_ready,
    output ssj_pkg::ssj_item_t   rd_item
);
    import ssj_pkg::*;

    ssj_item_t           entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg;
    logic [QUEUE_AW:0]   count_next;
    logic                push;
    logic                pop;

    assign wr_ready = (count_reg != (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_item  = entry_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + QUEUE_AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QUEUE_AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + (QUEUE_AW+1)'(1);
        end else if (pop && !push) begin
            count_next = count_reg - (QUEUE_AW+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

// ----- rtl/ssj_back.sv -----
// Back stage: join state, decisions and result sequencing for one record at a time.
`include "sorted_site_join_clean_filter_assert.svh"

module ssj_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  ssj_pkg::ssj_item_t   q_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output ssj_pkg::ssj_result_t m_result,
    output logic                 m_last
);
    import ssj_pkg::*;

    // Join state.
    logic [7:0]  head_chr_reg;
    logic [31:0] head_pos_reg;
    logic        head_clean_reg;
    logic        head_valid_reg;
    logic        done_reg;
    logic [7:0]  wait_chr_reg;
    logic [31:0] wait_pos_reg;
    logic        wait_clean_reg;
    logic        wait_valid_reg;
    logic [7:0]  cur_chr_reg;
    logic [31:0] ftc_reg;
    logic [31:0] found_total_reg;
    logic [31:0] missed_reg;
    logic [31:0] lines_reg;

    // Result sequencing and output register.
    logic [1:0]  idx_reg;
    logic [1:0]  idx_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    ssj_result_t out_res_reg;
    ssj_result_t out_res_next;
    logic        out_last_reg;
    logic        out_last_next;

    // Decision datapath.
    logic [7:0]  d_hchr;
    logic [31:0] d_hpos;
    logic        d_hclean;
    logic        d_hvalid;
    logic [7:0]  d_wchr;
    logic [31:0] d_wpos;
    logic        d_wclean;
    logic        key_ge;
    logic        match;
    logic        resolve_ok;
    logic        s2_order;
    logic        s2_take;
    logic        summ_s2;
    logic        decide;
    logic        need;
    logic        keep;
    logic        miss;
    logic [31:0] ftc_base;
    logic [31:0] ftc_new;
    logic [31:0] found_new;
    logic [31:0] missed_new;
    logic [31:0] lines_new;
    ssj_result_t dec_res;
    ssj_result_t need_res;
    ssj_result_t cand0;
    ssj_result_t cand1;
    ssj_result_t cand2;
    logic        en0;
    logic        en1;
    logic        en2;
    ssj_result_t res0;
    ssj_result_t res1;
    ssj_result_t sel_res;
    logic [1:0]  res_count;
    logic        is_last;
    logic        can_load;
    logic        load;
    logic        pop;

    // Head and waiting record as seen by this record's decision.
    always_comb begin
        d_hchr   = head_chr_reg;
        d_hpos   = head_pos_reg;
        d_hclean = head_clean_reg;
        d_hvalid = head_valid_reg;
        d_wchr   = wait_chr_reg;
        d_wpos   = wait_pos_reg;
        d_wclean = wait_clean_reg;
        if (q_item.mode == MODE_S1_REC) begin
            d_hchr   = q_item.chromosome;
            d_hpos   = q_item.position;
            d_hclean = q_item.clean;
            d_hvalid = 1'b1;
        end
        if (q_item.mode == MODE_S2_REC) begin
            d_wchr   = q_item.chromosome;
            d_wpos   = q_item.position;
            d_wclean = q_item.clean;
        end
    end

    assign key_ge     = ({d_hchr, d_hpos} >= {d_wchr, d_wpos});
    assign match      = d_hvalid && (d_hchr == d_wchr) && (d_hpos == d_wpos);
    assign resolve_ok = done_reg || (d_hvalid && key_ge);

    // Stream-2 record classification against the current chromosome.
    assign s2_order = (q_item.mode == MODE_S2_REC) && !wait_valid_reg
                   && (q_item.chromosome < cur_chr_reg);
    assign s2_take  = (q_item.mode == MODE_S2_REC) && !wait_valid_reg
                   && (q_item.chromosome >= cur_chr_reg);
    assign summ_s2  = s2_take && (q_item.chromosome != cur_chr_reg) && (cur_chr_reg != 8'd0);

    // Whether this record decides the waiting site or asks for more stream-1 records.
    always_comb begin
        decide = 1'b0;
        need   = 1'b0;
        case (q_item.mode)
            MODE_S1_REC: begin
                decide = !done_reg && wait_valid_reg && resolve_ok;
                need   = !done_reg && wait_valid_reg && !resolve_ok;
            end
            MODE_S2_REC: begin
                decide = s2_take && resolve_ok;
                need   = s2_take && !resolve_ok;
            end
            MODE_S1_END: decide = wait_valid_reg;
            MODE_S2_END: decide = wait_valid_reg;
            default: begin
                decide = 1'b0;
                need   = 1'b0;
            end
        endcase
    end

    // Counter updates.
    assign keep       = decide && match && d_hclean && d_wclean;
    assign miss       = decide && !match;
    assign ftc_base   = summ_s2 ? 32'd0 : ftc_reg;
    assign ftc_new    = keep ? sat_inc(ftc_base) : ftc_base;
    assign found_new  = keep ? sat_inc(found_total_reg) : found_total_reg;
    assign missed_new = miss ? sat_inc(missed_reg) : missed_reg;
    assign lines_new  = s2_take ? sat_inc(lines_reg) : lines_reg;

    always_comb begin
        dec_res.action     = keep ? ACT_KEEP : (match ? ACT_UNCLEAN : ACT_MISS);
        dec_res.chromosome = d_wchr;
        dec_res.position   = d_wpos;
        dec_res.found      = found_new;
        dec_res.missed     = missed_new;
        dec_res.lines      = lines_new;
        need_res           = dec_res;
        need_res.action    = ACT_NEED;
    end

    // Up to three candidate results in output order, with enables.
    always_comb begin
        cand0 = dec_res;
        cand1 = dec_res;
        cand2 = dec_res;
        en0   = 1'b0;
        en1   = 1'b0;
        en2   = 1'b0;
        case (q_item.mode)
            MODE_S1_REC: begin
                cand2 = decide ? dec_res : need_res;
                en2   = decide || need;
            end
            MODE_S2_REC: begin
                if (s2_order) begin
                    cand2.action     = ACT_ORDER;
                    cand2.chromosome = q_item.chromosome;
                    cand2.position   = q_item.position;
                    cand2.found      = found_total_reg;
                    cand2.missed     = missed_reg;
                    cand2.lines      = lines_reg;
                    en2              = 1'b1;
                end else if (s2_take) begin
                    cand0.action     = ACT_SUMMARY;
                    cand0.chromosome = cur_chr_reg;
                    cand0.position   = 32'd0;
                    cand0.found      = ftc_reg;
                    cand0.missed     = missed_reg;
                    cand0.lines      = lines_new;
                    en0              = summ_s2;
                    cand1.action     = ACT_BADREF;
                    cand1.chromosome = q_item.chromosome;
                    cand1.position   = q_item.position;
                    cand1.found      = found_total_reg;
                    cand1.missed     = missed_reg;
                    cand1.lines      = lines_new;
                    en1              = q_item.bad_ref;
                    cand2            = decide ? dec_res : need_res;
                    en2              = 1'b1;
                end
            end
            MODE_S1_END: begin
                en2 = decide;
            end
            MODE_S2_END: begin
                en0              = decide;
                cand1.action     = ACT_SUMMARY;
                cand1.chromosome = cur_chr_reg;
                cand1.position   = 32'd0;
                cand1.found      = ftc_new;
                cand1.missed     = missed_new;
                cand1.lines      = lines_reg;
                en1              = 1'b1;
                cand2.action     = ACT_TOTALS;
                cand2.chromosome = 8'd0;
                cand2.position   = 32'd0;
                cand2.found      = found_new;
                cand2.missed     = missed_new;
                cand2.lines      = lines_reg;
                en2              = 1'b1;
            end
            default: begin
                en2 = 1'b0;
            end
        endcase
    end

    // Pack the enabled candidates and pick the one at the current index.
    assign res0      = en0 ? cand0 : (en1 ? cand1 : cand2);
    assign res1      = (en0 && en1) ? cand1 : cand2;
    assign res_count = {1'b0, en0} + {1'b0, en1} + {1'b0, en2};

    always_comb begin
        case (idx_reg)
            2'd0:    sel_res = res0;
            2'd1:    sel_res = res1;
            default: sel_res = cand2;
        endcase
    end

    assign is_last  = (idx_reg == res_count - 2'd1);
    assign can_load = !out_valid_reg || m_ready;
    assign load     = q_valid && (res_count != 2'd0) && can_load;
    assign pop      = q_valid && ((res_count == 2'd0) || (can_load && is_last));
    assign q_ready  = pop;

    // Output register and result index.
    always_comb begin
        out_valid_next = out_valid_reg && !m_ready;
        out_res_next   = out_res_reg;
        out_last_next  = out_last_reg;
        idx_next       = idx_reg;
        if (load) begin
            out_valid_next = 1'b1;
            out_res_next   = sel_res;
            out_last_next  = is_last;
        end
        if (pop) begin
            idx_next = 2'd0;
        end else if (load) begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end else begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
        out_res_reg  <= out_res_next;
        out_last_reg <= out_last_next;
    end

    // Join state commits when the record leaves the queue.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_chr_reg    <= 8'd0;
            head_pos_reg    <= 32'd0;
            head_clean_reg  <= 1'b0;
            head_valid_reg  <= 1'b0;
            done_reg        <= 1'b0;
            wait_chr_reg    <= 8'd0;
            wait_pos_reg    <= 32'd0;
            wait_clean_reg  <= 1'b0;
            wait_valid_reg  <= 1'b0;
            cur_chr_reg     <= 8'd0;
            ftc_reg         <= 32'd0;
            found_total_reg <= 32'd0;
            missed_reg      <= 32'd0;
            lines_reg       <= 32'd0;
        end else if (pop) begin
            if ((q_item.mode == MODE_S1_REC) && !done_reg) begin
                head_chr_reg   <= q_item.chromosome;
                head_pos_reg   <= q_item.position;
                head_clean_reg <= q_item.clean;
                head_valid_reg <= 1'b1;
            end
            if (s2_take) begin
                cur_chr_reg    <= q_item.chromosome;
                wait_chr_reg   <= q_item.chromosome;
                wait_pos_reg   <= q_item.position;
                wait_clean_reg <= q_item.clean;
            end
            if (q_item.mode == MODE_S1_END) begin
                done_reg <= 1'b1;
            end
            if (decide) begin
                wait_valid_reg <= 1'b0;
            end else if (s2_take) begin
                wait_valid_reg <= 1'b1;
            end
            ftc_reg         <= ftc_new;
            found_total_reg <= found_new;
            missed_reg      <= missed_new;
            lines_reg       <= lines_new;
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_result = out_res_reg;
    assign m_last   = out_last_reg;

    // Per-chromosome count never passes the running total.
    `SSJ_ASSERT(a_ftc_within_total, aclk, aresetn, ftc_reg <= found_total_reg)
    // Once stream 1 has ended it stays ended.
    `SSJ_ASSERT(a_done_sticky, aclk, aresetn, done_reg |=> done_reg)
    // A record part way through its results is still at the queue head.
    `SSJ_ASSERT_NEVER(a_idx_without_item, aclk, aresetn, (idx_reg != 2'd0) && !q_valid)
    // A decided record leaves nothing waiting.
    `SSJ_ASSERT(a_decide_clears_wait, aclk, aresetn, (pop && decide) |=> !wait_valid_reg)

endmodule
